>>> rtl/e2h_pkg.sv
// ----------------------------------------------------------------------------
// e2h_pkg
// Shared types, constants and tables of the Euler-to-transform block.
// ----------------------------------------------------------------------------
package e2h_pkg;

	localparam int FRAC_BITS    = 16;
	localparam int CORDIC_STEPS = 20;
	localparam int DATA_W       = 32;

	// angle reduction
	localparam longint FULL_DEG    = longint'(360) << FRAC_BITS;
	localparam longint HALF_DEG    = longint'(180) << FRAC_BITS;
	localparam longint QUARTER_DEG = longint'(90) << FRAC_BITS;
	localparam int     RW          = FRAC_BITS + 9;
	localparam int     MAG_W       = FRAC_BITS + 7;

	// whole degrees modulo 360: offset to positive, then reciprocal multiply
	localparam int     H_W    = DATA_W - FRAC_BITS;
	localparam int     N_W    = H_W + 1;
	localparam longint H_OFF  = 360 * ((longint'(1) << (H_W - 1)) / 360 + 1);
	localparam int     S360   = N_W + 9;
	localparam longint M360   = ((longint'(1) << S360) + 359) / 360;
	localparam int     Q360_W = N_W - 8;

	// degree to radian: (mag * pi) / (45 << (FRAC_BITS + 2))
	localparam logic [31:0] PI_Q30    = 32'hC90FDAA2;
	localparam int          DIV_SHIFT = FRAC_BITS + 2;
	localparam int          V_W       = MAG_W + 32 - DIV_SHIFT;

	// divide by 45 in two halves, each by reciprocal multiply
	localparam int     VL_W = 18;
	localparam int     VH_W = V_W - VL_W;
	localparam int     QH_W = VH_W - 5;
	localparam int     SH45 = VH_W + 6;
	localparam longint MH45 = ((longint'(1) << SH45) + 44) / 45;
	localparam int     SL45 = VL_W + 12;
	localparam longint ML45 = ((longint'(1) << SL45) + 44) / 45;

	// CORDIC
	localparam int                CW       = 34;
	localparam logic signed [CW-1:0] CORDIC_K = 34'sh026DD3B6A;
	localparam int                ROT_STEPS = (CORDIC_STEPS < 31) ? CORDIC_STEPS : 31;
	localparam int                MUL_STEPS = 14;

	localparam logic [1:0]  LAST_ROW = 2'd3;
	localparam logic [31:0] ONE_OUT  = 32'(longint'(1) << FRAC_BITS);

	typedef struct packed {
		logic signed [31:0] roll_deg;
		logic signed [31:0] pitch_deg;
		logic signed [31:0] yaw_deg;
		logic signed [31:0] translation_x;
		logic signed [31:0] translation_y;
		logic signed [31:0] translation_z;
	} pose_t;

	typedef struct packed {
		logic [1:0]         row_index;
		logic signed [31:0] col0;
		logic signed [31:0] col1;
		logic signed [31:0] col2;
		logic signed [31:0] col3;
		logic               last_row;
	} row_t;

	// one reduced pose, passed from front to back
	typedef struct packed {
		logic signed [31:0] z_roll;
		logic signed [31:0] z_pitch;
		logic signed [31:0] z_yaw;
		logic [2:0]         negc;
		logic signed [31:0] tx;
		logic signed [31:0] ty;
		logic signed [31:0] tz;
	} job_t;

	typedef struct packed {
		logic idle;
		logic done;
	} lane_stat_t;

	typedef enum logic [3:0] {
		A_IDLE, A_QUO, A_REM, A_FOLD, A_MUL, A_DIVH, A_REMH, A_DIVL, A_DONE
	} ang_state_t;

	typedef enum logic [1:0] {
		B_IDLE, B_ROT, B_MUL, B_EMIT
	} back_state_t;

	// truncated Q30 arctangent table
	function automatic logic [29:0] atan_q30(input logic [4:0] i);
		logic [29:0] v;
		case (i)
			5'd0:  v = 30'h3243F6A8;
			5'd1:  v = 30'h1DAC6705;
			5'd2:  v = 30'h0FADBAFC;
			5'd3:  v = 30'h07F56EA6;
			5'd4:  v = 30'h03FEAB76;
			5'd5:  v = 30'h01FFD55B;
			5'd6:  v = 30'h00FFFAAA;
			5'd7:  v = 30'h007FFF55;
			5'd8:  v = 30'h003FFFEA;
			5'd9:  v = 30'h001FFFFD;
			5'd10: v = 30'h000FFFFF;
			5'd11: v = 30'h0007FFFF;
			5'd12: v = 30'h0003FFFF;
			5'd13: v = 30'h0001FFFF;
			5'd14: v = 30'h0000FFFF;
			5'd15: v = 30'h00007FFF;
			5'd16: v = 30'h00003FFF;
			5'd17: v = 30'h00001FFF;
			5'd18: v = 30'h00000FFF;
			5'd19: v = 30'h000007FF;
			5'd20: v = 30'h000003FF;
			5'd21: v = 30'h000001FF;
			5'd22: v = 30'h000000FF;
			5'd23: v = 30'h0000007F;
			5'd24: v = 30'h0000003F;
			5'd25: v = 30'h0000001F;
			5'd26: v = 30'h0000000F;
			5'd27: v = 30'h00000008;
			5'd28: v = 30'h00000004;
			5'd29: v = 30'h00000002;
			5'd30: v = 30'h00000001;
			default: v = 30'h0;
		endcase
		return v;
	endfunction

endpackage

>>> rtl/e2h_stream_if.sv
// ----------------------------------------------------------------------------
// e2h_stream_if
// Valid/ready stream channel carrying one payload per beat.
// ----------------------------------------------------------------------------
interface e2h_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/e2h_angle.sv
// ----------------------------------------------------------------------------
// e2h_angle
// Angle reduction lane: modulo one turn, fold to +-90 degrees, then degrees
// to Q30 radians by one multiply and a divide by 45; the modulo and the
// divide are done by reciprocal multiplies, one registered state per step.
// ----------------------------------------------------------------------------
module e2h_angle (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               ack,
	input  logic signed [31:0] angle,
	output e2h_pkg::lane_stat_t stat,
	output logic signed [31:0] z,
	output logic               negc
);
	import e2h_pkg::*;

	localparam logic signed [RW+1:0] FULL_S = (RW+2)'(FULL_DEG);
	localparam logic signed [RW+1:0] HALF_S = (RW+2)'(HALF_DEG);
	localparam logic signed [RW+1:0] QTR_S  = (RW+2)'(QUARTER_DEG);
	localparam logic [N_W-1:0]       OFF_N  = N_W'(H_OFF);
	localparam logic [N_W:0]         M360_C = (N_W+1)'(M360);
	localparam logic [VH_W:0]        MH_C   = (VH_W+1)'(MH45);
	localparam logic [VL_W+6:0]      ML_C   = (VL_W+7)'(ML45);

	ang_state_t st_q, st_d;
	logic [N_W-1:0]       num_q;
	logic [FRAC_BITS-1:0] frac_q;
	logic [Q360_W-1:0]    turns_q;
	logic [RW-1:0]        red_q;
	logic [MAG_W-1:0]     mag_q;
	logic                 neg_q, negc_q;
	logic [V_W-1:0]       v_q;
	logic [QH_W-1:0]      qh_q;
	logic [VL_W+5:0]      n2_q;
	logic [31:0]          quo_q;

	logic [2*N_W:0]       turns_p;
	logic [N_W-1:0]       deg_rem;
	logic signed [RW+1:0] fm, fr, ff;
	logic                 fneg;
	logic [MAG_W+31:0]    prod;
	logic [2*VH_W:0]      qh_p;
	logic [VH_W-1:0]      rh;
	logic [2*VL_W+12:0]   ql_p;

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			A_IDLE: if (start) st_d = A_QUO;
			A_QUO:  st_d = A_REM;
			A_REM:  st_d = A_FOLD;
			A_FOLD: st_d = A_MUL;
			A_MUL:  st_d = A_DIVH;
			A_DIVH: st_d = A_REMH;
			A_REMH: st_d = A_DIVL;
			A_DIVL: st_d = A_DONE;
			A_DONE: if (ack) st_d = A_IDLE;
			default: st_d = A_IDLE;
		endcase
	end

	// status outputs
	always_comb begin
		stat.idle = (st_q == A_IDLE);
		stat.done = (st_q == A_DONE);
	end

	// whole turns in the offset degree count, and what is left of it
	assign turns_p = (2*N_W+1)'(num_q) * (2*N_W+1)'(M360_C);
	assign deg_rem = num_q - N_W'(turns_q) * N_W'(360);

	// center the reduced angle on zero, fold to +-90
	always_comb begin
		fm = $signed({2'b00, red_q});
		fr = (fm >= HALF_S) ? fm - FULL_S : fm;
		fneg = 1'b0;
		if (fr > QTR_S) begin
			ff = HALF_S - fr;
			fneg = 1'b1;
		end else if (fr < -QTR_S) begin
			ff = -HALF_S - fr;
			fneg = 1'b1;
		end else begin
			ff = fr;
		end
	end

	assign prod = (MAG_W+32)'(mag_q) * (MAG_W+32)'(PI_Q30);

	// divide by 45: upper half, its remainder, then lower half
	assign qh_p = (2*VH_W+1)'(v_q[V_W-1:VL_W]) * (2*VH_W+1)'(MH_C);
	assign rh   = v_q[V_W-1:VL_W] - VH_W'(qh_q) * VH_W'(45);
	assign ql_p = (2*VL_W+13)'(n2_q) * (2*VL_W+13)'(ML_C);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= A_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (st_q)
			A_IDLE: begin
				num_q  <= N_W'($signed(angle[31:FRAC_BITS])) + OFF_N;
				frac_q <= angle[FRAC_BITS-1:0];
			end
			A_QUO: turns_q <= turns_p[2*N_W:S360];
			A_REM: red_q <= {deg_rem[8:0], frac_q};
			A_FOLD: begin
				mag_q  <= (ff < 0) ? MAG_W'(-ff) : MAG_W'(ff);
				neg_q  <= (ff < 0);
				negc_q <= fneg;
			end
			A_MUL:  v_q <= prod[MAG_W+31:DIV_SHIFT];
			A_DIVH: qh_q <= qh_p[SH45 +: QH_W];
			A_REMH: n2_q <= {rh[5:0], v_q[VL_W-1:0]};
			A_DIVL: quo_q <= {qh_q, ql_p[SL45 +: VL_W]};
			default: ;
		endcase
	end

	assign z    = neg_q ? -$signed(quo_q) : $signed(quo_q);
	assign negc = negc_q;

endmodule

>>> rtl/e2h_front.sv
// ----------------------------------------------------------------------------
// e2h_front
// Accepts poses into a holding register and reduces the three angles in
// parallel lanes; pushes each reduced pose toward the back end.
// ----------------------------------------------------------------------------
module e2h_front (
	input  logic          clk,
	input  logic          arst_n,
	e2h_stream_if.sink    pose,
	output e2h_pkg::job_t job,
	output logic          job_valid,
	input  logic          job_ready
);
	import e2h_pkg::*;

	logic       in_full_q;
	pose_t      pose_q;
	logic signed [31:0] tx_q, ty_q, tz_q;
	lane_stat_t st_r, st_p, st_y;
	logic signed [31:0] z_r, z_p, z_y;
	logic       nc_r, nc_p, nc_y;
	logic       start, all_done, ack;

	assign pose.ready = !in_full_q;
	assign start      = in_full_q && st_r.idle && st_p.idle && st_y.idle;
	assign all_done   = st_r.done && st_p.done && st_y.done;
	assign ack        = all_done && job_ready;

	// holding register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) in_full_q <= 1'b0;
		else if (pose.valid && pose.ready) in_full_q <= 1'b1;
		else if (start) in_full_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (pose.valid && pose.ready) begin
			pose_q.roll_deg      <= pose.payload.roll_deg;
			pose_q.pitch_deg     <= pose.payload.pitch_deg;
			pose_q.yaw_deg       <= pose.payload.yaw_deg;
			pose_q.translation_x <= pose.payload.translation_x;
			pose_q.translation_y <= pose.payload.translation_y;
			pose_q.translation_z <= pose.payload.translation_z;
		end
		if (start) begin
			tx_q <= pose_q.translation_x;
			ty_q <= pose_q.translation_y;
			tz_q <= pose_q.translation_z;
		end
	end

	e2h_angle u_roll (.clk, .arst_n, .start, .ack, .angle(pose_q.roll_deg),
		.stat(st_r), .z(z_r), .negc(nc_r));
	e2h_angle u_pitch (.clk, .arst_n, .start, .ack, .angle(pose_q.pitch_deg),
		.stat(st_p), .z(z_p), .negc(nc_p));
	e2h_angle u_yaw (.clk, .arst_n, .start, .ack, .angle(pose_q.yaw_deg),
		.stat(st_y), .z(z_y), .negc(nc_y));

	// reduced pose
	always_comb begin
		job.z_roll  = z_r;
		job.z_pitch = z_p;
		job.z_yaw   = z_y;
		job.negc    = {nc_y, nc_p, nc_r};
		job.tx      = tx_q;
		job.ty      = ty_q;
		job.tz      = tz_q;
	end
	assign job_valid = all_done;

endmodule

>>> rtl/e2h_queue.sv
// ----------------------------------------------------------------------------
// e2h_queue
// Two-entry queue of reduced poses between front and back end.
// ----------------------------------------------------------------------------
module e2h_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  e2h_pkg::job_t push_data,
	input  logic          push_valid,
	output logic          push_ready,
	output e2h_pkg::job_t pop_data,
	output logic          pop_valid,
	input  logic          pop_ready
);
	import e2h_pkg::*;

	job_t       mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       do_push, do_pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= !wr_q;
			if (do_pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= push_data;
	end

endmodule

>>> rtl/e2h_back.sv
// ----------------------------------------------------------------------------
// e2h_back
// Three CORDIC lanes give sine and cosine, one shared multiplier builds the
// rotation matrix, then the four rows leave through an output register.
// ----------------------------------------------------------------------------
module e2h_back (
	input  logic          clk,
	input  logic          arst_n,
	input  e2h_pkg::job_t job,
	input  logic          job_valid,
	output logic          job_ready,
	e2h_stream_if.source  row
);
	import e2h_pkg::*;

	localparam logic [4:0] ROT_LAST = 5'(ROT_STEPS - 1);
	localparam logic [3:0] MUL_END  = 4'(MUL_STEPS);

	back_state_t st_q, st_d;
	logic [4:0] cnt_q;
	logic [3:0] step_q;
	logic [1:0] row_q;
	logic       out_v_q;
	row_t       out_q;

	logic signed [CW-1:0] x_q [3];
	logic signed [CW-1:0] y_q [3];
	logic signed [CW-1:0] z_q [3];
	logic [2:0]           negc_q;
	logic signed [31:0]   tx_q, ty_q, tz_q;

	logic signed [63:0]   mul_s1;
	logic [3:0]           dst_s1;
	logic                 wr_s1;

	logic signed [CW-1:0] m00, m01, m02, m10, m11, m12, m21, m22;
	logic signed [CW-1:0] czsy, szsy, szcx, szsx, czcx, czsx;

	logic signed [CW-1:0] x_nx [3];
	logic signed [CW-1:0] y_nx [3];
	logic signed [CW-1:0] z_nx [3];
	logic signed [31:0]   sx, cx, sy, cy, sz, cz;
	logic signed [31:0]   op_a, op_b;
	logic signed [63:0]   rnd_sum;
	logic signed [CW-1:0] rnd, m20;
	logic                 issue, pop, out_free, load;
	row_t                 row_nx;

	function automatic logic signed [31:0] to_out(input logic signed [CW-1:0] q);
		logic signed [CW:0] t;
		logic signed [CW:0] s;
		t = {q[CW-1], q} + ((CW+1)'(1) <<< (29 - FRAC_BITS));
		s = t >>> (30 - FRAC_BITS);
		return s[31:0];
	endfunction

	assign job_ready = (st_q == B_IDLE);
	assign pop       = job_valid && job_ready;
	assign out_free  = !out_v_q || row.ready;

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			B_IDLE: if (job_valid) st_d = B_ROT;
			B_ROT:  if (cnt_q == ROT_LAST) st_d = B_MUL;
			B_MUL:  if (step_q == MUL_END) st_d = B_EMIT;
			B_EMIT: if (out_free && row_q == LAST_ROW) st_d = B_IDLE;
			default: st_d = B_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		issue = (st_q == B_MUL) && (step_q != MUL_END);
		load  = (st_q == B_EMIT) && out_free;
	end

	// CORDIC rotation step per lane
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			if (z_q[l] >= 0) begin
				x_nx[l] = x_q[l] - (y_q[l] >>> cnt_q);
				y_nx[l] = y_q[l] + (x_q[l] >>> cnt_q);
				z_nx[l] = z_q[l] - $signed({4'b0, atan_q30(cnt_q)});
			end else begin
				x_nx[l] = x_q[l] + (y_q[l] >>> cnt_q);
				y_nx[l] = y_q[l] - (x_q[l] >>> cnt_q);
				z_nx[l] = z_q[l] + $signed({4'b0, atan_q30(cnt_q)});
			end
		end
	end

	// sine and cosine, lanes are roll, pitch, yaw
	always_comb begin
		sx = y_q[0][31:0];
		sy = y_q[1][31:0];
		sz = y_q[2][31:0];
		cx = negc_q[0] ? 32'(-x_q[0]) : x_q[0][31:0];
		cy = negc_q[1] ? 32'(-x_q[1]) : x_q[1][31:0];
		cz = negc_q[2] ? 32'(-x_q[2]) : x_q[2][31:0];
		m20 = -CW'(sy);
	end

	// multiplier operand schedule
	always_comb begin
		op_a = cz;
		op_b = cy;
		case (step_q)
			4'd0:  begin op_a = cz; op_b = cy; end
			4'd1:  begin op_a = cz; op_b = sy; end
			4'd2:  begin op_a = sz; op_b = cx; end
			4'd3:  begin op_a = sz; op_b = sx; end
			4'd4:  begin op_a = sz; op_b = cy; end
			4'd5:  begin op_a = sz; op_b = sy; end
			4'd6:  begin op_a = cz; op_b = cx; end
			4'd7:  begin op_a = cz; op_b = sx; end
			4'd8:  begin op_a = cy; op_b = sx; end
			4'd9:  begin op_a = cy; op_b = cx; end
			4'd10: begin op_a = czsy[31:0]; op_b = sx; end
			4'd11: begin op_a = czsy[31:0]; op_b = cx; end
			4'd12: begin op_a = szsy[31:0]; op_b = sx; end
			4'd13: begin op_a = szsy[31:0]; op_b = cx; end
			default: ;
		endcase
	end

	// Q30 rounding of the registered product
	assign rnd_sum = mul_s1 + (64'sd1 <<< 29);
	assign rnd     = rnd_sum[63:30];

	// row being loaded
	always_comb begin
		row_nx.row_index = row_q;
		row_nx.last_row  = (row_q == LAST_ROW);
		case (row_q)
			2'd0: begin
				row_nx.col0 = to_out(m00);
				row_nx.col1 = to_out(m01);
				row_nx.col2 = to_out(m02);
				row_nx.col3 = tx_q;
			end
			2'd1: begin
				row_nx.col0 = to_out(m10);
				row_nx.col1 = to_out(m11);
				row_nx.col2 = to_out(m12);
				row_nx.col3 = ty_q;
			end
			2'd2: begin
				row_nx.col0 = to_out(m20);
				row_nx.col1 = to_out(m21);
				row_nx.col2 = to_out(m22);
				row_nx.col3 = tz_q;
			end
			default: begin
				row_nx.col0 = '0;
				row_nx.col1 = '0;
				row_nx.col2 = '0;
				row_nx.col3 = ONE_OUT;
			end
		endcase
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= B_IDLE;
			cnt_q   <= '0;
			step_q  <= '0;
			row_q   <= '0;
			wr_s1   <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			st_q  <= st_d;
			wr_s1 <= issue;
			cnt_q <= (st_q == B_ROT && st_d == B_ROT) ? cnt_q + 5'd1 : '0;
			step_q <= (st_q == B_MUL && st_d == B_MUL) ? step_q + 4'd1 : '0;
			if (st_q != B_EMIT) row_q <= '0;
			else if (load) row_q <= row_q + 2'd1;
			if (load) out_v_q <= 1'b1;
			else if (row.ready) out_v_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (pop) begin
			for (int l = 0; l < 3; l++) begin
				x_q[l] <= CORDIC_K;
				y_q[l] <= '0;
			end
			z_q[0] <= CW'(job.z_roll);
			z_q[1] <= CW'(job.z_pitch);
			z_q[2] <= CW'(job.z_yaw);
			negc_q <= job.negc;
			tx_q   <= job.tx;
			ty_q   <= job.ty;
			tz_q   <= job.tz;
		end else if (st_q == B_ROT) begin
			for (int l = 0; l < 3; l++) begin
				x_q[l] <= x_nx[l];
				y_q[l] <= y_nx[l];
				z_q[l] <= z_nx[l];
			end
		end
		mul_s1 <= op_a * op_b;
		dst_s1 <= step_q;
		if (wr_s1) begin
			case (dst_s1)
				4'd0:  m00  <= rnd;
				4'd1:  czsy <= rnd;
				4'd2:  szcx <= rnd;
				4'd3:  szsx <= rnd;
				4'd4:  m10  <= rnd;
				4'd5:  szsy <= rnd;
				4'd6:  czcx <= rnd;
				4'd7:  czsx <= rnd;
				4'd8:  m21  <= rnd;
				4'd9:  m22  <= rnd;
				4'd10: m01  <= rnd - szcx;
				4'd11: m02  <= rnd + szsx;
				4'd12: m11  <= rnd + czcx;
				4'd13: m12  <= rnd - czsx;
				default: ;
			endcase
		end
		if (load) out_q <= row_nx;
	end

	assign row.valid   = out_v_q;
	assign row.payload = out_q;

endmodule

>>> rtl/euler_to_homogeneous_transform.sv
// ----------------------------------------------------------------------------
// euler_to_homogeneous_transform
// Roll/pitch/yaw in degrees plus translation to a 4x4 homogeneous
// transform, emitted as four row beats.
//
//   channel | dir | beat payload
//   pose    | in  | roll_deg pitch_deg yaw_deg translation_x/y/z
//   row     | out | row_index col0 col1 col2 col3 last_row
//
// Each angle lane does modulo-360 and divide-by-45 by reciprocal multiplies.
// The back end sets the rate and takes a new pose only when idle: a pop,
// 20 CORDIC steps, 14 products on one multiplier, then 4 row beats.
// A two-entry queue and the output register let either side stall.
// Reset clears control only.
// ----------------------------------------------------------------------------
module euler_to_homogeneous_transform (
	input  logic         clk,
	input  logic         arst_n,
	e2h_stream_if.sink   pose,
	e2h_stream_if.source row
);
	import e2h_pkg::*;

	job_t f_job, b_job;
	logic f_valid, f_ready, b_valid, b_ready;

	e2h_front u_front (
		.clk, .arst_n, .pose,
		.job(f_job), .job_valid(f_valid), .job_ready(f_ready)
	);

	e2h_queue u_queue (
		.clk, .arst_n,
		.push_data(f_job), .push_valid(f_valid), .push_ready(f_ready),
		.pop_data(b_job), .pop_valid(b_valid), .pop_ready(b_ready)
	);

	e2h_back u_back (
		.clk, .arst_n,
		.job(b_job), .job_valid(b_valid), .job_ready(b_ready),
		.row
	);

endmodule

>>> rtl/e2h_checker.sv
// ----------------------------------------------------------------------------
// e2h_checker
// Port-level checks on the row channel, bound to the top level.
// ----------------------------------------------------------------------------
module e2h_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        row_valid,
	input logic        row_ready,
	input logic [1:0]  row_index,
	input logic [31:0] col0,
	input logic [31:0] col1,
	input logic [31:0] col2,
	input logic [31:0] col3,
	input logic        last_row
);
	import e2h_pkg::*;

	logic [1:0] exp_q;

	// expected row of the next beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) exp_q <= '0;
		else if (row_valid && row_ready) exp_q <= exp_q + 2'd1;
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		row_valid && !row_ready |=> row_valid && $stable(row_index))
		else $error("row beat dropped while stalled");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		row_valid |-> row_index == exp_q)
		else $error("rows out of order");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		row_valid |-> (last_row == (row_index == LAST_ROW)))
		else $error("last flag on wrong row");

	a_bottom: assert property (@(posedge clk) disable iff (!arst_n)
		row_valid && last_row |->
			col0 == 32'd0 && col1 == 32'd0 && col2 == 32'd0 && col3 == ONE_OUT)
		else $error("bottom row is not 0 0 0 1");

endmodule

bind euler_to_homogeneous_transform e2h_checker u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.row_valid(row.valid),
	.row_ready(row.ready),
	.row_index(row.payload.row_index),
	.col0(row.payload.col0),
	.col1(row.payload.col1),
	.col2(row.payload.col2),
	.col3(row.payload.col3),
	.last_row(row.payload.last_row)
);
